// ===== sv/awtc_pkg.sv =====
// ----------------------------------------------------------------------------
// awtc_pkg: shared types and constants for the ack window timeout controller
// Field widths, reset values, event codes and the state/result records.
// ----------------------------------------------------------------------------
package awtc_pkg;

  localparam int unsigned WinW   = 8;
  localparam int unsigned TmoW   = 22;
  localparam int unsigned AckW   = 32;
  localparam int unsigned DupW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TmoW-1:0] TmoMax     = 22'd4194303;
  localparam logic [TmoW-1:0] MsUs       = 22'd1000;
  localparam logic [TmoW-1:0] TmoFloor   = 22'd10000;
  localparam logic [WinW-1:0] WinFloor   = 8'd3;
  localparam logic [WinW-1:0] WinSmall   = 8'd4;
  localparam logic [WinW-1:0] WinReopen  = 8'd10;
  localparam logic [DupW-1:0] DupMax     = 3'd7;
  localparam logic [DupW-1:0] DupFirst   = 3'd3;
  localparam logic [DupW-1:0] DupSecond  = 3'd6;

  localparam logic [WinW-1:0] WinLimitRst = 8'd32;
  localparam logic [TmoW-1:0] InitTmoRst  = 22'd125000;
  localparam logic [TmoW-1:0] TmoCapRst   = 22'd3000000;

  localparam logic [1:0] ResendNone  = 2'd0;
  localparam logic [1:0] ResendOne   = 2'd1;
  localparam logic [1:0] ResendThree = 2'd3;

  typedef enum logic [2:0] {
    EV_NEW     = 3'd0,
    EV_DUP     = 3'd1,
    EV_OLD     = 3'd2,
    EV_INVALID = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LIMIT = 2'd0,
    CFG_INIT_TMO     = 2'd1,
    CFG_TMO_CAP      = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_ACK     = 1'b0,
    FUNC_TIMEOUT = 1'b1
  } func_e;

  typedef struct packed {
    logic [AckW-1:0] highest_ack;
    logic [DupW-1:0] dup_count;
    logic [WinW-1:0] window;
    logic [TmoW-1:0] timeout;
  } ctl_state_t;

  typedef struct packed {
    logic            func;
    logic            ack_ok;
    logic [AckW-1:0] ack_number;
  } beat_in_t;

  typedef struct packed {
    logic [WinW-1:0] window_limit;
    logic [TmoW-1:0] timeout_cap;
  } ctl_cfg_t;

  typedef struct packed {
    event_kind_e     kind;
    logic [WinW-1:0] window;
    logic [TmoW-1:0] timeout;
    logic [AckW-1:0] acked_level;
    logic [1:0]      resend;
    logic            restart;
  } beat_out_t;

endpackage

// ===== sv/awtc_update.sv =====
// ----------------------------------------------------------------------------
// awtc_update: next-state and result logic for one event
// Classifies the event and computes the new window, timeout, ack level and
// duplicate count along with the resend and restart requests.
// ----------------------------------------------------------------------------
module awtc_update import awtc_pkg::*; (
  input  ctl_state_t state_i,
  input  beat_in_t   beat_i,
  input  ctl_cfg_t   cfg_i,
  output ctl_state_t state_o,
  output beat_out_t  result_o
);

  logic [TmoW:0]   tmo_dbl;
  logic [TmoW:0]   tmo_inc;
  logic [DupW-1:0] dup_inc;

  assign tmo_dbl = {state_i.timeout, 1'b0};
  assign tmo_inc = {1'b0, state_i.timeout} + {1'b0, MsUs};
  assign dup_inc = (state_i.dup_count < DupMax) ? state_i.dup_count + 3'd1
                                                : state_i.dup_count;

  always_comb begin
    state_o          = state_i;
    result_o.kind    = EV_OLD;
    result_o.resend  = ResendNone;
    result_o.restart = 1'b0;

    priority if (beat_i.func == FUNC_TIMEOUT) begin
      if (tmo_dbl > {1'b0, cfg_i.timeout_cap}) begin
        state_o.timeout = cfg_i.timeout_cap;
      end else begin
        state_o.timeout = tmo_dbl[TmoW-1:0];
      end
      if (state_i.window <= WinSmall) begin
        state_o.window = WinReopen;
      end else begin
        state_o.window = state_i.window >> 1;
      end
      state_o.dup_count = '0;
      result_o.restart  = 1'b1;
      result_o.kind     = EV_TIMEOUT;
    end else if (!beat_i.ack_ok) begin
      state_o.dup_count = '0;
      result_o.restart  = 1'b1;
      result_o.kind     = EV_INVALID;
    end else if (beat_i.ack_number > state_i.highest_ack) begin
      state_o.highest_ack = beat_i.ack_number;
      state_o.dup_count   = '0;
      if (state_i.timeout > TmoFloor) begin
        state_o.timeout = state_i.timeout - MsUs;
      end
      if (state_i.window < cfg_i.window_limit) begin
        state_o.window = state_i.window + 8'd1;
      end
      result_o.kind = EV_NEW;
    end else if (beat_i.ack_number == state_i.highest_ack) begin
      // duplicate: saturating timeout growth, window shrink, fast resend
      state_o.timeout   = tmo_inc[TmoW] ? TmoMax : tmo_inc[TmoW-1:0];
      state_o.dup_count = dup_inc;
      if (state_i.window > WinFloor) begin
        state_o.window = state_i.window - 8'd1;
      end
      if (dup_inc == DupSecond) begin
        result_o.resend = ResendThree;
      end else if (dup_inc == DupFirst) begin
        result_o.resend = ResendOne;
      end
      result_o.kind = EV_DUP;
    end else begin
      result_o.kind = EV_OLD;
    end

    result_o.window      = state_o.window;
    result_o.timeout     = state_o.timeout;
    result_o.acked_level = state_o.highest_ack;
  end

endmodule

// ===== sv/ack_window_timeout_controller_unit.sv =====
// ----------------------------------------------------------------------------
// ack_window_timeout_controller_unit: sender-side window/timeout control
// Pipeline: an input beat passes through the input reg, then the result reg.
// Throughput: one event per cycle unless out_ready_i stalls the result reg.
// Reset: async active low; limit and cap regs go to 32 / 3000000, state to
// ack 0, dup 0, window 32, timeout 125000. Both pipe stages empty.
// ----------------------------------------------------------------------------
module ack_window_timeout_controller_unit import awtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TmoW-1:0]     cfg_wdata_i,
  // event input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic                ack_ok_i,
  input  logic [AckW-1:0]     ack_number_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          event_kind_o,
  output logic [WinW-1:0]     window_size_o,
  output logic [TmoW-1:0]     timeout_us_o,
  output logic [AckW-1:0]     acked_level_o,
  output logic [1:0]          resend_count_o,
  output logic                restart_window_o
);

  // Configuration registers. The initial timeout only sets the reset load of
  // the timeout state, which uses the fixed reset value, so a write to it has
  // no effect and nothing is stored. A later write never touches state.
  logic [WinW-1:0] win_limit_q;
  logic [TmoW-1:0] tmo_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_limit_q <= WinLimitRst;
      tmo_cap_q   <= TmoCapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_LIMIT: win_limit_q <= cfg_wdata_i[WinW-1:0];
        CFG_INIT_TMO:     ;  // reset-only value, write dropped
        CFG_TMO_CAP:      tmo_cap_q   <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Stage 1: input register. Stage 2: result register.
  // The state update happens as a beat moves from stage 1 to stage 2, so
  // consecutive beats see each other's effect with no bubble.
  logic       s1_valid_q;
  beat_in_t   s1_beat_q;
  logic       s2_valid_q;
  beat_out_t  s2_res_q;
  logic       s2_free;
  logic       s1_move;
  logic       in_take;

  assign s2_free    = !s2_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_beat_q <= '{func: func_i, ack_ok: ack_ok_i, ack_number: ack_number_i};
    end
  end

  // Controller state
  ctl_state_t state_q, state_d;
  beat_out_t  res_d;
  ctl_cfg_t   cfg;

  assign cfg = '{window_limit: win_limit_q, timeout_cap: tmo_cap_q};

  awtc_update u_update (
    .state_i  (state_q),
    .beat_i   (s1_beat_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{highest_ack: '0, dup_count: '0,
                   window: WinLimitRst, timeout: InitTmoRst};
    end else if (s1_move) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_res_q <= res_d;
    end
  end

  assign out_valid_o      = s2_valid_q;
  assign event_kind_o     = s2_res_q.kind;
  assign window_size_o    = s2_res_q.window;
  assign timeout_us_o     = s2_res_q.timeout;
  assign acked_level_o    = s2_res_q.acked_level;
  assign resend_count_o   = s2_res_q.resend;
  assign restart_window_o = s2_res_q.restart;

endmodule
